// ===== sv/pra_pkg.sv =====
package pra_pkg;

    localparam int LOC_W      = 48;
    localparam int LEN_W      = 32;
    localparam int STATUS_W   = 3;
    localparam int RSV_W      = 11;
    localparam int CFG_W      = 48;
    localparam int IN_DATA_W  = 80;
    localparam int OUT_DATA_W = 56;
    localparam int OUT_PAD_W  = OUT_DATA_W - STATUS_W - LOC_W;

    // The bitmap is held as words of this many page bits.
    localparam int WORD_BITS  = 32;
    localparam int WORD_SHIFT = 5;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic REG_BASE  = 1'b0;
    localparam logic REG_PAGES = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
    localparam logic [STATUS_W-1:0] ST_MISALIGN   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NO_RESERVE = 3'd2;
    localparam logic [STATUS_W-1:0] ST_BEYOND     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_PAGE_USED  = 3'd4;

    typedef struct packed {
        logic rd;
        logic wr;
        logic wipe;
        logic set;
    } bm_ctrl_t;

endpackage

// ===== sv/page_range_allocation_map_top.sv =====
// Page range allocator: one in-use bit per page of a reserved region.
// Requests arrive on the s_ side: s_tuser selects alloc (0) or free (1),
// s_tdata carries the location and the length in bytes. Every request gives
// exactly one result on the m_ side: a status code and the granted address.
// The cfg channel writes the region base (index 0) and its page count
// (index 1); it is always ready. It must be written only while the block
// is idle; the block itself does not enforce this. One request is worked
// on at a time. The bitmap lives in a single-port memory of 32-page words,
// and each word touched is read, then evaluated or written back. An alloc
// makes a check pass and then a set pass over the words of its range, a
// free makes one clear pass only, and a request that fails its address
// checks touches no word.
// The result sits in an output register, so the next request is taken while
// an earlier result is still stalled; a stalled receiver holds m_tdata and
// blocks only the finish of the following request.
// After reset the bitmap is wiped one word per cycle, through all of its
// words, before s_tready rises; both config registers reset to zero.
module page_range_allocation_map_top
    import pra_pkg::*;
#(
    parameter int PAGE_BYTES = 4096,
    parameter int MAX_PAGES  = 1024
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // location[47:0], length_bytes[79:48]
    input  logic                  s_tuser,   // cmd[0]
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // status[2:0], granted_address[50:3], zero
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic                  cfg_index,
    input  logic [CFG_W-1:0]      cfg_data
);

    localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
    localparam int PAGE_NUM_W = $clog2(MAX_PAGES + 1);
    localparam int PXW  = (PAGE_NUM_W > WORD_SHIFT) ? PAGE_NUM_W : WORD_SHIFT + 1;
    localparam int UW   = (PXW > RSV_W) ? PXW : RSV_W;
    localparam int ROWS = (MAX_PAGES + WORD_BITS - 1) / WORD_BITS;
    localparam int RAW  = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int WW   = PXW - WORD_SHIFT;
    localparam int FW   = LOC_W + 1 - PAGE_SHIFT;
    localparam int CW   = LEN_W + 1 - PAGE_SHIFT;

    localparam logic [3:0] S_CLEAR    = 4'd0;
    localparam logic [3:0] S_IDLE     = 4'd1;
    localparam logic [3:0] S_PREP     = 4'd2;
    localparam logic [3:0] S_ALIGN    = 4'd3;
    localparam logic [3:0] S_RANGE    = 4'd4;
    localparam logic [3:0] S_CHECK_RD = 4'd5;
    localparam logic [3:0] S_CHECK_EV = 4'd6;
    localparam logic [3:0] S_SET_RD   = 4'd7;
    localparam logic [3:0] S_SET_WR   = 4'd8;
    localparam logic [3:0] S_DONE     = 4'd9;

    logic [3:0]          state_reg, state_next;
    logic                cmd_reg, cmd_next;
    logic [LOC_W-1:0]    loc_reg, loc_next;
    logic [LEN_W-1:0]    len_reg, len_next;
    logic [LOC_W-1:0]    base_reg;
    logic [RSV_W-1:0]    rsv_reg;
    logic                mis_reg, mis_next;
    logic                nobase_reg, nobase_next;
    logic [LOC_W-1:0]    off_reg, off_next;
    logic [FW-1:0]       first_reg, first_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [PXW-1:0]      lo_reg, lo_next;
    logic [PXW-1:0]      hi_reg, hi_next;
    logic [WW-1:0]       w_reg, w_next;
    logic [WW-1:0]       last_w_reg, last_w_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [LOC_W-1:0]    grant_reg, grant_next;
    logic                m_valid_reg, m_valid_next;
    logic [STATUS_W-1:0] m_status_reg, m_status_next;
    logic [LOC_W-1:0]    m_grant_reg, m_grant_next;

    logic [LEN_W:0]         len_up;
    logic [LOC_W:0]         off_up;
    logic [PAGE_SHIFT:0]    shrink;
    logic [LEN_W-1:0]       shrink_ext;
    logic [LEN_W-1:0]       len_trim;
    logic [FW:0]            end_sum;
    logic [UW-1:0]          rsv_ext;
    logic [UW-1:0]          usable_u;
    logic [PXW-1:0]         usable;
    logic                   over;
    logic [PXW-1:0]         hi_m1;
    logic                   hit;
    bm_ctrl_t               bm_ctrl;

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = {{OUT_PAD_W{1'b0}}, m_grant_reg, m_status_reg};

    pra_bitmap #(
        .ROWS (ROWS),
        .RAW  (RAW),
        .WW   (WW),
        .PXW  (PXW)
    ) u_bitmap (
        .clk  (clk),
        .ctrl (bm_ctrl),
        .addr (w_reg),
        .lo   (lo_reg),
        .hi   (hi_reg),
        .hit  (hit)
    );

    // Shared arithmetic of the preparation states.
    always_comb
    begin
        len_up     = {1'b0, len_reg} + (LEN_W+1)'(PAGE_BYTES - 1);
        off_up     = {1'b0, off_reg} + (LOC_W+1)'(PAGE_BYTES - 1);
        shrink     = (off_reg[PAGE_SHIFT-1:0] == '0) ? '0
                     : (PAGE_SHIFT+1)'(PAGE_BYTES) - {1'b0, off_reg[PAGE_SHIFT-1:0]};
        shrink_ext = LEN_W'(shrink);
        len_trim   = (len_reg > shrink_ext) ? len_reg - shrink_ext : '0;
        end_sum    = {1'b0, first_reg} + (FW+1)'(count_reg);
        rsv_ext    = UW'(rsv_reg);
        usable_u   = (rsv_ext > UW'(MAX_PAGES)) ? UW'(MAX_PAGES) : rsv_ext;
        usable     = PXW'(usable_u);
        over       = end_sum > (FW+1)'(usable);
        hi_m1      = end_sum[PXW-1:0] - PXW'(1);
    end

    always_comb
    begin
        state_next    = state_reg;
        cmd_next      = cmd_reg;
        loc_next      = loc_reg;
        len_next      = len_reg;
        mis_next      = mis_reg;
        nobase_next   = nobase_reg;
        off_next      = off_reg;
        first_next    = first_reg;
        count_next    = count_reg;
        lo_next       = lo_reg;
        hi_next       = hi_reg;
        w_next        = w_reg;
        last_w_next   = last_w_reg;
        status_next   = status_reg;
        grant_next    = grant_reg;
        m_valid_next  = m_valid_reg;
        m_status_next = m_status_reg;
        m_grant_next  = m_grant_reg;
        bm_ctrl       = '0;

        if (m_valid_reg && m_tready)
        begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                bm_ctrl.wr   = 1'b1;
                bm_ctrl.wipe = 1'b1;
                if (w_reg == WW'(ROWS - 1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    w_next = w_reg + WW'(1);
                end
            end
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd_next   = s_tuser;
                    loc_next   = s_tdata[LOC_W-1:0];
                    len_next   = s_tdata[LOC_W +: LEN_W];
                    state_next = S_PREP;
                end
            end
            S_PREP:
            begin
                if (cmd_reg == CMD_ALLOC)
                begin
                    mis_next    = |loc_reg[PAGE_SHIFT-1:0];
                    nobase_next = (base_reg == '0);
                    off_next    = base_reg + loc_reg;
                    first_next  = {1'b0, loc_reg[LOC_W-1:PAGE_SHIFT]};
                    count_next  = len_up[LEN_W:PAGE_SHIFT];
                    state_next  = S_RANGE;
                end
                else
                begin
                    mis_next    = 1'b0;
                    nobase_next = 1'b0;
                    off_next    = loc_reg - base_reg;
                    state_next  = S_ALIGN;
                end
            end
            S_ALIGN:
            begin
                // Free: round the offset up to a page and shrink the length by
                // the same amount before cutting it to whole pages.
                first_next = off_up[LOC_W:PAGE_SHIFT];
                count_next = {1'b0, len_trim[LEN_W-1:PAGE_SHIFT]};
                state_next = S_RANGE;
            end
            S_RANGE:
            begin
                lo_next     = first_reg[PXW-1:0];
                hi_next     = end_sum[PXW-1:0];
                w_next      = first_reg[PXW-1:WORD_SHIFT];
                last_w_next = hi_m1[PXW-1:WORD_SHIFT];
                grant_next  = '0;
                if (cmd_reg == CMD_ALLOC)
                begin
                    priority if (mis_reg)
                    begin
                        status_next = ST_MISALIGN;
                        state_next  = S_DONE;
                    end
                    else if (nobase_reg)
                    begin
                        status_next = ST_NO_RESERVE;
                        state_next  = S_DONE;
                    end
                    else if (over)
                    begin
                        status_next = ST_BEYOND;
                        state_next  = S_DONE;
                    end
                    else if (count_reg == '0)
                    begin
                        status_next = ST_OK;
                        grant_next  = off_reg;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        state_next = S_CHECK_RD;
                    end
                end
                else
                begin
                    status_next = ST_OK;
                    if (over || count_reg == '0)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_SET_RD;
                    end
                end
            end
            S_CHECK_RD:
            begin
                bm_ctrl.rd = 1'b1;
                state_next = S_CHECK_EV;
            end
            S_CHECK_EV:
            begin
                priority if (hit)
                begin
                    status_next = ST_PAGE_USED;
                    grant_next  = '0;
                    state_next  = S_DONE;
                end
                else if (w_reg == last_w_reg)
                begin
                    w_next     = lo_reg[PXW-1:WORD_SHIFT];
                    state_next = S_SET_RD;
                end
                else
                begin
                    w_next     = w_reg + WW'(1);
                    state_next = S_CHECK_RD;
                end
            end
            S_SET_RD:
            begin
                bm_ctrl.rd = 1'b1;
                state_next = S_SET_WR;
            end
            S_SET_WR:
            begin
                bm_ctrl.wr  = 1'b1;
                bm_ctrl.set = (cmd_reg == CMD_ALLOC);
                if (w_reg == last_w_reg)
                begin
                    status_next = ST_OK;
                    grant_next  = (cmd_reg == CMD_ALLOC) ? off_reg : '0;
                    state_next  = S_DONE;
                end
                else
                begin
                    w_next     = w_reg + WW'(1);
                    state_next = S_SET_RD;
                end
            end
            S_DONE:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    m_valid_next  = 1'b1;
                    m_status_next = status_reg;
                    m_grant_next  = grant_reg;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            w_reg       <= '0;
            m_valid_reg <= 1'b0;
            base_reg    <= '0;
            rsv_reg     <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            w_reg       <= w_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    REG_BASE:  base_reg <= cfg_data;
                    REG_PAGES: rsv_reg  <= cfg_data[RSV_W-1:0];
                    default:   ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        loc_reg      <= loc_next;
        len_reg      <= len_next;
        mis_reg      <= mis_next;
        nobase_reg   <= nobase_next;
        off_reg      <= off_next;
        first_reg    <= first_next;
        count_reg    <= count_next;
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        last_w_reg   <= last_w_next;
        status_reg   <= status_next;
        grant_reg    <= grant_next;
        m_status_reg <= m_status_next;
        m_grant_reg  <= m_grant_next;
    end

endmodule

// ===== sv/pra_bitmap.sv =====
module pra_bitmap
    import pra_pkg::*;
#(
    parameter int ROWS = 32,
    parameter int RAW  = 5,
    parameter int WW   = 6,
    parameter int PXW  = 11
)
(
    input  logic           clk,
    input  bm_ctrl_t       ctrl,
    input  logic [WW-1:0]  addr,
    input  logic [PXW-1:0] lo,
    input  logic [PXW-1:0] hi,
    output logic           hit
);

    logic [WORD_BITS-1:0] mem [0:ROWS-1];
    logic [WORD_BITS-1:0] rd_q_reg;

    logic [WORD_SHIFT-1:0] lo_bit;
    logic [WORD_BITS-1:0]  hi_mask;
    logic [WORD_BITS-1:0]  mask;
    logic [WORD_BITS-1:0]  wdata;

    // Page range [lo, hi) cut down to the bits of the addressed word.
    always_comb
    begin
        lo_bit  = (addr == lo[PXW-1:WORD_SHIFT]) ? lo[WORD_SHIFT-1:0] : '0;
        hi_mask = (addr == hi[PXW-1:WORD_SHIFT])
                  ? ((WORD_BITS'(1) << hi[WORD_SHIFT-1:0]) - WORD_BITS'(1))
                  : {WORD_BITS{1'b1}};
        mask    = ({WORD_BITS{1'b1}} << lo_bit) & hi_mask;
        if (ctrl.wipe)
        begin
            wdata = '0;
        end
        else if (ctrl.set)
        begin
            wdata = rd_q_reg | mask;
        end
        else
        begin
            wdata = rd_q_reg & ~mask;
        end
    end

    assign hit = |(rd_q_reg & mask);

    always_ff @(posedge clk)
    begin
        if (ctrl.rd)
        begin
            rd_q_reg <= mem[addr[RAW-1:0]];
        end
        if (ctrl.wr)
        begin
            mem[addr[RAW-1:0]] <= wdata;
        end
    end

endmodule

// ===== sv/pra_checker.sv =====
module pra_checker
    import pra_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata
);

    // Only one request is in work at a time.
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request taken while another is in work");

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[STATUS_W-1:0] <= ST_PAGE_USED))
        else $error("status code out of range");

    // A failed allocation never grants an address.
    a_fail_no_grant: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[STATUS_W-1:0] != ST_OK)
        |-> (m_tdata[STATUS_W +: LOC_W] == '0))
        else $error("address granted with a failing status");

    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[OUT_DATA_W-1:STATUS_W+LOC_W] == '0))
        else $error("padding bits of result not zero");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed");

endmodule

bind page_range_allocation_map_top pra_checker u_pra_checker (.*);
